@@ hw/rtl/sn2d_pkg.sv @@
`timescale 1ns / 1ps
// Package for the 2D simplex noise evaluator: fixed-point constants, opcode
// and gradient types, and the hash-to-gradient lookup. No dependencies.
package sn2d_pkg;

    localparam int TABLE_SIZE              = 256;
    localparam int TAB_AW                  = 8;
    localparam int IFRAC                   = 30;
    localparam int DEFAULT_COORD_FRAC_BITS = 16;

    localparam logic signed [29:0] F2_Q30   = 30'sd393016785;
    localparam logic signed [28:0] G2_Q30   = 29'sd226908346;
    localparam logic signed [29:0] G2X2_Q30 = 30'sd453816692;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } op_t;

    typedef struct packed {
        logic signed [1:0] gx;
        logic signed [1:0] gy;
    } grad_t;

    function automatic grad_t grad_of(input logic [7:0] hv);
        logic [7:0] m;
        grad_t      g;
        m = hv;
        if (m >= 8'd192) m = m - 8'd192;
        if (m >= 8'd96)  m = m - 8'd96;
        if (m >= 8'd48)  m = m - 8'd48;
        if (m >= 8'd24)  m = m - 8'd24;
        if (m >= 8'd12)  m = m - 8'd12;
        case (m)
            8'd0:    g = '{gx: 2'sd1,  gy: 2'sd1};
            8'd1:    g = '{gx: -2'sd1, gy: 2'sd1};
            8'd2:    g = '{gx: 2'sd1,  gy: -2'sd1};
            8'd3:    g = '{gx: -2'sd1, gy: -2'sd1};
            8'd4:    g = '{gx: 2'sd1,  gy: 2'sd0};
            8'd5:    g = '{gx: -2'sd1, gy: 2'sd0};
            8'd6:    g = '{gx: 2'sd1,  gy: 2'sd0};
            8'd7:    g = '{gx: -2'sd1, gy: 2'sd0};
            8'd8:    g = '{gx: 2'sd0,  gy: 2'sd1};
            8'd9:    g = '{gx: 2'sd0,  gy: -2'sd1};
            8'd10:   g = '{gx: 2'sd0,  gy: 2'sd1};
            8'd11:   g = '{gx: 2'sd0,  gy: -2'sd1};
            default: g = '{gx: 2'sd0,  gy: 2'sd0};
        endcase
        return g;
    endfunction

endpackage

@@ hw/rtl/sn2d_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module sn2d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/simplex_noise_2d.sv @@
`timescale 1ns / 1ps
// Top level of the 2D simplex noise evaluator: 14-stage pipeline.
// Depends on sn2d_pkg and sn2d_ram.
//
// Usage:
//   Input stream (s_): tuser carries the opcode. A load transfer writes
//   table_value at table_index of the 256-entry permutation table and
//   yields no result. An evaluate transfer carries coord_x/coord_y
//   (signed, COORD_FRAC_BITS fraction bits) and yields one noise_value on
//   the output stream (m_), signed Q1.14, clamped to [-16384, 16384].
//   Results leave in input order.
//   Throughput: one transfer per cycle; each stage holds one item and
//   empty stages close up, so s_tready stays high unless every stage is
//   full and the output is stalled.
//   The table lives in six replicated RAMs (two for the first hash level,
//   four for the second); a load writes them as it passes the read stages,
//   so evaluate items see exactly the loads that came before them.
//   Reset clears all valid bits; table contents are undefined until
//   loaded. When m_tready is low the output holds and the pipeline fills
//   behind it.
module simplex_noise_2d #(
    parameter int COORD_FRAC_BITS = sn2d_pkg::DEFAULT_COORD_FRAC_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // table_index[7:0], table_value[15:8],
                                   // coord_x[47:16], coord_y[79:48]
    input  logic [0:0]  s_tuser,   // opcode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // noise_value[15:0]
);

    import sn2d_pkg::*;

    localparam int CF   = COORD_FRAC_BITS;
    localparam int PXW  = 32 + IFRAC - CF;
    localparam int PW   = 63;
    localparam int SW   = PW - CF;
    localparam int AW   = ((SW > PXW) ? SW : PXW) + 1;
    localparam int IW   = AW - IFRAC;
    localparam int TPW  = IW + 30;
    localparam int EW   = ((TPW > AW) ? TPW : AW) + 2;
    localparam int DW   = 33;
    localparam int DTW  = DW + 2;
    localparam int SQW  = 2 * DW;
    localparam int FW   = SQW + 1 - IFRAC;
    localparam int QDW  = 31 + DTW;
    localparam int CW   = QDW - IFRAC;
    localparam int SUMW = CW + 2;
    localparam int RW   = SUMW + 8;
    localparam int NS   = 14;

    localparam logic signed [DW+1:0] ONE_E  = (DW+2)'(64'sd1 <<< IFRAC);
    localparam logic signed [DW+1:0] G2_E   = (DW+2)'(G2_Q30);
    localparam logic signed [DW+1:0] G2X2_E = (DW+2)'(G2X2_Q30);
    localparam logic [FW-1:0]        HALF_F = FW'(64'd1 << (IFRAC - 1));
    localparam logic signed [7:0]    K70    = 8'sd70;
    localparam logic signed [RW:0]   RND    = (RW+1)'(64'sd32768);
    localparam logic signed [RW-16:0] SAT_HI = (RW-15)'(64'sd16384);
    localparam logic signed [RW-16:0] SAT_LO = -(RW-15)'(64'sd16384);

    // stage control
    logic [NS:1] v_reg;
    logic [NS:1] en;

    always_comb begin
        en[NS] = !v_reg[NS] || m_tready;
        for (int k = NS - 1; k >= 1; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    op_t op_in;
    assign op_in = op_t'(s_tuser[0]);

    logic op4_eval;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 1; k <= NS; k++) begin
                if (en[k]) begin
                    if (k == 1) begin
                        v_reg[k] <= s_tvalid;
                    end else if (k == 5) begin
                        v_reg[k] <= v_reg[4] && op4_eval;
                    end else begin
                        v_reg[k] <= v_reg[k-1];
                    end
                end
            end
        end
    end

    assign s_tready = en[1];

    // stages 1-4: skew, floor, unskew product
    op_t                    op1_reg, op2_reg, op3_reg, op4_reg;
    logic [7:0]             idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic [7:0]             val1_reg, val2_reg, val3_reg, val4_reg;
    logic signed [31:0]     x1_reg, x2_reg, x3_reg, x4_reg;
    logic signed [31:0]     y1_reg, y2_reg, y3_reg, y4_reg;
    logic signed [32:0]     sxy1_reg;
    logic signed [PW-1:0]   prod2_reg;
    logic signed [IW-1:0]   i3_reg, j3_reg, i4_reg, j4_reg;
    logic signed [TPW-1:0]  t4_reg;

    logic signed [32:0]     sxy_next;
    logic signed [PW-1:0]   prod_next;
    logic signed [SW-1:0]   s3;
    logic signed [PXW-1:0]  px2, py2, px4, py4;
    logic signed [AW-1:0]   ax, ay;
    logic signed [IW:0]     ij;
    logic signed [TPW-1:0]  t_next;

    assign sxy_next  = 33'($signed(s_tdata[47:16])) + 33'($signed(s_tdata[79:48]));
    assign prod_next = PW'(sxy1_reg * F2_Q30);
    assign s3        = $signed(prod2_reg[PW-1:CF]);
    assign px2       = $signed({x2_reg, {(IFRAC-CF){1'b0}}});
    assign py2       = $signed({y2_reg, {(IFRAC-CF){1'b0}}});
    assign ax        = AW'(px2) + AW'(s3);
    assign ay        = AW'(py2) + AW'(s3);
    assign ij        = (IW+1)'(i3_reg) + (IW+1)'(j3_reg);
    assign t_next    = TPW'(ij * G2_Q30);
    assign op4_eval  = (op4_reg == OP_EVAL);

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            op1_reg  <= op_in;
            idx1_reg <= s_tdata[7:0];
            val1_reg <= s_tdata[15:8];
            x1_reg   <= $signed(s_tdata[47:16]);
            y1_reg   <= $signed(s_tdata[79:48]);
            sxy1_reg <= sxy_next;
        end
        if (en[2]) begin
            op2_reg   <= op1_reg;
            idx2_reg  <= idx1_reg;
            val2_reg  <= val1_reg;
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            prod2_reg <= prod_next;
        end
        if (en[3]) begin
            op3_reg  <= op2_reg;
            idx3_reg <= idx2_reg;
            val3_reg <= val2_reg;
            x3_reg   <= x2_reg;
            y3_reg   <= y2_reg;
            i3_reg   <= ax[AW-1:IFRAC];
            j3_reg   <= ay[AW-1:IFRAC];
        end
        if (en[4]) begin
            op4_reg  <= op3_reg;
            idx4_reg <= idx3_reg;
            val4_reg <= val3_reg;
            x4_reg   <= x3_reg;
            y4_reg   <= y3_reg;
            i4_reg   <= i3_reg;
            j4_reg   <= j3_reg;
            t4_reg   <= t_next;
        end
    end

    // permutation table, two hash levels
    logic             wr_l1, wr_l2;
    logic [TAB_AW-1:0] jj3, ii4;
    logic [7:0]       ta4, tb4;
    logic [7:0]       r0_5, rl_5, ru_5, r2_5;
    logic [TAB_AW-1:0] raddr_l2 [4];
    logic [7:0]       rdata_l2 [4];

    assign wr_l1 = v_reg[3] && (op3_reg == OP_LOAD) && en[4];
    assign wr_l2 = v_reg[4] && (op4_reg == OP_LOAD) && en[5];
    assign jj3   = j3_reg[TAB_AW-1:0];
    assign ii4   = i4_reg[TAB_AW-1:0];

    sn2d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_a (
        .aclk(aclk), .we(wr_l1), .waddr(idx3_reg), .wdata(val3_reg),
        .re(en[4]), .raddr(jj3), .rdata(ta4)
    );

    sn2d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_b (
        .aclk(aclk), .we(wr_l1), .waddr(idx3_reg), .wdata(val3_reg),
        .re(en[4]), .raddr(jj3 + TAB_AW'(1)), .rdata(tb4)
    );

    assign raddr_l2[0] = ii4 + ta4;
    assign raddr_l2[1] = ii4 + ta4 + TAB_AW'(1);
    assign raddr_l2[2] = ii4 + tb4;
    assign raddr_l2[3] = ii4 + tb4 + TAB_AW'(1);

    for (genvar g = 0; g < 4; g++) begin : gen_l2
        sn2d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram (
            .aclk(aclk), .we(wr_l2), .waddr(idx4_reg), .wdata(val4_reg),
            .re(en[5]), .raddr(raddr_l2[g]), .rdata(rdata_l2[g])
        );
    end

    assign r0_5 = rdata_l2[0];
    assign rl_5 = rdata_l2[1];
    assign ru_5 = rdata_l2[2];
    assign r2_5 = rdata_l2[3];

    // stage 5: cell-relative offsets
    logic signed [EW-1:0] x0w, y0w;
    logic signed [DW-1:0] x0_5_reg, y0_5_reg;

    assign px4 = $signed({x4_reg, {(IFRAC-CF){1'b0}}});
    assign py4 = $signed({y4_reg, {(IFRAC-CF){1'b0}}});
    assign x0w = EW'(px4) - (EW'(i4_reg) <<< IFRAC) + EW'(t4_reg);
    assign y0w = EW'(py4) - (EW'(j4_reg) <<< IFRAC) + EW'(t4_reg);

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            x0_5_reg <= x0w[DW-1:0];
            y0_5_reg <= y0w[DW-1:0];
        end
    end

    // stage 6: triangle, corner offsets, gradients
    logic                 lower;
    logic signed [DW+1:0] x0e, y0e, x1w, y1w, x2w, y2w;
    logic signed [DW-1:0] dx6_reg [3];
    logic signed [DW-1:0] dy6_reg [3];
    grad_t                gr6_reg [3];

    assign lower = x0_5_reg > y0_5_reg;
    assign x0e   = (DW+2)'(x0_5_reg);
    assign y0e   = (DW+2)'(y0_5_reg);
    assign x1w   = x0e - (lower ? ONE_E : '0) + G2_E;
    assign y1w   = y0e - (lower ? '0 : ONE_E) + G2_E;
    assign x2w   = x0e - ONE_E + G2X2_E;
    assign y2w   = y0e - ONE_E + G2X2_E;

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            dx6_reg[0] <= x0_5_reg;
            dy6_reg[0] <= y0_5_reg;
            dx6_reg[1] <= x1w[DW-1:0];
            dy6_reg[1] <= y1w[DW-1:0];
            dx6_reg[2] <= x2w[DW-1:0];
            dy6_reg[2] <= y2w[DW-1:0];
            gr6_reg[0] <= grad_of(r0_5);
            gr6_reg[1] <= grad_of(lower ? rl_5 : ru_5);
            gr6_reg[2] <= grad_of(r2_5);
        end
    end

    // stages 7-12: per-corner falloff and gradient dot, then the corner sum
    logic [SQW-1:0]        sqx7_reg [3];
    logic [SQW-1:0]        sqy7_reg [3];
    logic signed [DTW-1:0] dot7_reg [3];
    logic signed [DTW-1:0] dot8_reg [3];
    logic signed [DTW-1:0] dot9_reg [3];
    logic signed [DTW-1:0] dot10_reg [3];
    logic [29:0]           d8_reg [3];
    logic [3:0]            z_reg [3];
    logic [59:0]           dd9_reg [3];
    logic [59:0]           d2sq10_reg [3];
    logic signed [QDW-1:0] qd11_reg [3];
    logic signed [SUMW-1:0] sum12_reg;

    logic signed [DTW-1:0] tx [3];
    logic signed [DTW-1:0] ty [3];
    logic [SQW:0]          ss [3];
    logic [FW-1:0]         fl [3];
    logic [FW-1:0]         dw [3];
    logic [29:0]           d2 [3];
    logic [29:0]           qv [3];
    logic signed [CW-1:0]  cv [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            case (gr6_reg[k].gx)
                2'sd1:   tx[k] = DTW'(dx6_reg[k]);
                -2'sd1:  tx[k] = -DTW'(dx6_reg[k]);
                default: tx[k] = '0;
            endcase
            case (gr6_reg[k].gy)
                2'sd1:   ty[k] = DTW'(dy6_reg[k]);
                -2'sd1:  ty[k] = -DTW'(dy6_reg[k]);
                default: ty[k] = '0;
            endcase
            ss[k] = (SQW+1)'(sqx7_reg[k]) + (SQW+1)'(sqy7_reg[k]);
            fl[k] = ss[k][SQW:IFRAC];
            dw[k] = HALF_F - fl[k];
            d2[k] = dd9_reg[k][59:30];
            qv[k] = d2sq10_reg[k][59:30];
            cv[k] = z_reg[k][3] ? '0 : qd11_reg[k][QDW-1:IFRAC];
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            if (en[7]) begin
                sqx7_reg[k] <= SQW'(dx6_reg[k] * dx6_reg[k]);
                sqy7_reg[k] <= SQW'(dy6_reg[k] * dy6_reg[k]);
                dot7_reg[k] <= tx[k] + ty[k];
            end
            if (en[8]) begin
                d8_reg[k]   <= (fl[k] > HALF_F) ? '0 : dw[k][29:0];
                z_reg[k][0] <= fl[k] > HALF_F;
                dot8_reg[k] <= dot7_reg[k];
            end
            if (en[9]) begin
                dd9_reg[k]  <= d8_reg[k] * d8_reg[k];
                z_reg[k][1] <= z_reg[k][0];
                dot9_reg[k] <= dot8_reg[k];
            end
            if (en[10]) begin
                d2sq10_reg[k] <= d2[k] * d2[k];
                z_reg[k][2]   <= z_reg[k][1];
                dot10_reg[k]  <= dot9_reg[k];
            end
            if (en[11]) begin
                qd11_reg[k] <= QDW'($signed({1'b0, qv[k]}) * dot10_reg[k]);
                z_reg[k][3] <= z_reg[k][2];
            end
        end
        if (en[12]) begin
            sum12_reg <= SUMW'(cv[0]) + SUMW'(cv[1]) + SUMW'(cv[2]);
        end
    end

    // stages 13-14: scale, round, clamp
    logic signed [RW-1:0]  r13_reg;
    logic signed [RW:0]    rr;
    logic signed [RW-16:0] qn;
    logic [15:0]           out_next;
    logic [15:0]           out14_reg;

    assign rr = (RW+1)'(r13_reg) + RND;
    assign qn = rr[RW:16];

    always_comb begin
        if (qn > SAT_HI) begin
            out_next = SAT_HI[15:0];
        end else if (qn < SAT_LO) begin
            out_next = SAT_LO[15:0];
        end else begin
            out_next = qn[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[13]) begin
            r13_reg <= RW'(sum12_reg * K70);
        end
        if (en[14]) begin
            out14_reg <= out_next;
        end
    end

    assign m_tvalid = v_reg[NS];
    assign m_tdata  = out14_reg;

    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata) <= 16'sd16384 && $signed(m_tdata) >= -16'sd16384))
        else $error("noise result outside clamp range");

    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[4] && (op4_reg == OP_LOAD) && en[5]) |=> !v_reg[5])
        else $error("table load entered the evaluate stages");

endmodule

@@ tb/simplex_noise_2d_checker.sv @@
`timescale 1ns / 1ps
// Checker for the 2D simplex noise evaluator: watches both streams, keeps its
// own permutation table, predicts each noise value and compares. Uses sn2d_pkg.
module simplex_noise_2d_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    output int          fail_count,
    output int          pending_count,
    output int          eval_count
);

    import sn2d_pkg::*;

    localparam longint ONE = 64'sd1 <<< 30;
    localparam longint F2  = 64'sd393016785;
    localparam longint G2  = 64'sd226908346;
    localparam longint G2X2 = 64'sd453816692;

    logic [7:0]         perm_copy [256];
    logic signed [15:0] noise_queue [$];

    function automatic longint fdiv(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint falloff(longint dx, longint dy, logic [7:0] hv);
        longint d, d2, q, dot;
        int g;
        int gx, gy;
        g = hv % 12;
        case (g)
            0: begin gx = 1;  gy = 1;  end
            1: begin gx = -1; gy = 1;  end
            2: begin gx = 1;  gy = -1; end
            3: begin gx = -1; gy = -1; end
            4, 6: begin gx = 1;  gy = 0; end
            5, 7: begin gx = -1; gy = 0; end
            8, 10: begin gx = 0; gy = 1;  end
            default: begin gx = 0; gy = -1; end
        endcase
        d = (ONE >>> 1) - fdiv(dx * dx + dy * dy, 30);
        if (d < 0) return 0;
        d2 = fdiv(d * d, 30);
        q = fdiv(d2 * d2, 30);
        dot = gx * dx + gy * dy;
        return fdiv(q * dot, 30);
    endfunction

    function automatic logic signed [15:0] noise_at(logic signed [31:0] cx,
                                                    logic signed [31:0] cy);
        longint x, y, px, py, s, i, j, t, x0, y0, x1, y1, x2, y2, sum, r, q;
        logic [7:0] ii, jj, h0, h1, h2;
        int i1, j1;
        x = cx;
        y = cy;
        px = x <<< 14;
        py = y <<< 14;
        s = fdiv((x + y) * F2, 16);
        i = fdiv(px + s, 30);
        j = fdiv(py + s, 30);
        t = (i + j) * G2;
        x0 = px - i * ONE + t;
        y0 = py - j * ONE + t;
        if (x0 > y0) begin i1 = 1; j1 = 0; end else begin i1 = 0; j1 = 1; end
        x1 = x0 - i1 * ONE + G2;
        y1 = y0 - j1 * ONE + G2;
        x2 = x0 - ONE + G2X2;
        y2 = y0 - ONE + G2X2;
        ii = i[7:0];
        jj = j[7:0];
        h0 = perm_copy[8'(ii + perm_copy[jj])];
        h1 = perm_copy[8'(ii + i1 + perm_copy[8'(jj + j1)])];
        h2 = perm_copy[8'(ii + 1 + perm_copy[8'(jj + 1)])];
        sum = falloff(x0, y0, h0) + falloff(x1, y1, h1) + falloff(x2, y2, h2);
        r = 70 * sum;
        q = fdiv(r + (64'sd1 <<< 15), 16);
        if (q > 16384) q = 16384;
        if (q < -16384) q = -16384;
        return q[15:0];
    endfunction

    assign pending_count = noise_queue.size();

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fail_count <= 0;
            eval_count <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (op_t'(s_tuser[0]) == OP_LOAD) begin
                    perm_copy[s_tdata[7:0]] = s_tdata[15:8];
                end else begin
                    noise_queue = {noise_queue, noise_at(s_tdata[47:16], s_tdata[79:48])};
                end
            end
            if (m_tvalid && m_tready) begin
                eval_count <= eval_count + 1;
                if (noise_queue.size() == 0) begin
                    $error("noise_value: unexpected transfer %0d", $signed(m_tdata));
                    fail_count <= fail_count + 1;
                end else if (noise_queue[0] !== m_tdata) begin
                    $error("noise_value: expected %0d actual %0d",
                           noise_queue[0], $signed(m_tdata));
                    fail_count <= fail_count + 1;
                    void'(noise_queue.pop_front());
                end else begin
                    void'(noise_queue.pop_front());
                end
            end
        end
    end

endmodule

@@ tb/simplex_noise_2d_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the 2D simplex noise evaluator: clock, reset, stimulus
// and verdict. Depends on sn2d_pkg, simplex_noise_2d and the checker.
module simplex_noise_2d_tb;
    import sn2d_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    int          fail_count, pending_count, eval_count;
    int          idle_cycles = 0;
    int          load_count = 0;
    bit          hold_off = 1'b0;
    bit          hold_done = 1'b0;

    always #5 aclk = ~aclk;

    simplex_noise_2d i_dut (.*);

    simplex_noise_2d_checker i_checker (.*);

    always @(posedge aclk) begin
        if (aresetn && !hold_off)
            m_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
        else
            m_tready <= 1'b0;
    end

    // hold the receiver off once while the sender keeps offering
    initial begin
        wait (eval_count > 200);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (60) @(posedge aclk);
        hold_off <= 1'b0;
        hold_done <= 1'b1;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send(op_t op, logic [7:0] idx, logic [7:0] val,
                        logic [31:0] cx, logic [31:0] cy);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {cy, cx, val, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op == OP_LOAD) load_count++;
    endtask

    task automatic gap();
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return 32'($urandom_range(0, 3)) << 16;
        endcase
    endfunction

    initial begin
        logic [31:0] edges [6];
        int burst;
        edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                  32'h0001_0000, 32'h0000_8000};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // fill the whole table first, identity for the lower half then random bytes
        for (int k = 0; k < 256; k++) begin
            send(OP_LOAD, 8'(k), (k < 128) ? 8'(k) : 8'($urandom), '0, '0);
            if ($urandom_range(0, 15) == 0) gap();
        end
        // extreme coordinates and the table extremes
        send(OP_LOAD, 8'd255, 8'd255, '0, '0);
        send(OP_LOAD, 8'd0, 8'd0, '0, '0);
        for (int a = 0; a < 6; a++)
            for (int b = 0; b < 3; b++)
                send(OP_EVAL, 8'hFF, 8'hFF, edges[a], edges[b * 2 + (a % 2)]);
        drain();
        // random bursts, loads mixed with evaluations
        for (int n = 0; n < 1330; ) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++, n++) begin
                if ($urandom_range(0, 9) == 0)
                    send(OP_LOAD, 8'($urandom), 8'($urandom), $urandom, $urandom);
                else
                    send(OP_EVAL, 8'($urandom), 8'($urandom), rand_coord(), rand_coord());
            end
            if (n > 800 && n < 840) drain();
            else if ($urandom_range(0, 2) != 0) gap();
        end
        drain();
        $display("Covered %0d table loads and %0d noise evaluations, with random gaps,",
                 load_count, eval_count);
        $display("receiver stalls and one long back-pressure stretch (done=%0d).",
                 hold_done);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/sn2d_pkg.sv
hw/rtl/sn2d_ram.sv
hw/rtl/simplex_noise_2d.sv
tb/simplex_noise_2d_checker.sv
tb/simplex_noise_2d_tb.sv
